### src/assert_macros.svh
// Assertion macros shared by the stepper move controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication: when ante holds, cons must hold.
`define SMTP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define SMTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SMTP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SMTP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### src/smtp_pkg.sv
// Shared types and constants for the stepper move-to-position controller.
`timescale 1ns / 1ps

package smtp_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned CfgW   = 31;
  localparam int unsigned DtW    = 16;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned ApbW   = 32;

  localparam logic [CfgW-1:0] MaxSpeedReset = CfgW'(65536);
  localparam logic [CfgW-1:0] MaxAccelReset = CfgW'(65536);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_GOAL   = 2'd1,
    OP_CANCEL = 2'd2,
    OP_ZERO   = 2'd3
  } op_t;

  // Register indexes (paddr[2]).
  localparam logic REG_MAX_SPEED = 1'b0;
  localparam logic REG_MAX_ACCEL = 1'b1;

  typedef struct packed {
    logic [CfgW-1:0] max_speed;
    logic [CfgW-1:0] max_accel;
  } cfg_t;

  // Registered input word plus its precomputed speed step.
  typedef struct packed {
    op_t             op;
    logic [PosW-1:0] goal;
    logic [DtW-1:0]  dt;
    logic [CfgW-1:0] step;
  } item_t;

endpackage

### src/stepper_move_to_position.sv
// A word accepted into the input reg is loaded into the state reg when the core takes it,
// and the state reg drives its result.
// Throughput: one word per cycle unless the consumer stalls. The state update (speed*dt,
// saturating add, stop check, slew) is combinational; each word sees the last word's state.
// Reset (rst, synchronous): position 0, goal 0, speed 0, reached 1, limits 1.0 rev/s, rev/s^2.
// No clearing pass; the block takes words in the first cycle after reset.
`timescale 1ns / 1ps

module stepper_move_to_position (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [smtp_pkg::AddrW-1:0]  paddr,
  input  logic [smtp_pkg::ApbW-1:0]   pwdata,
  output logic [smtp_pkg::ApbW-1:0]   prdata,
  output logic                        pready,
  // Command words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  op,
  input  logic [smtp_pkg::PosW-1:0]   goal_position,
  input  logic [smtp_pkg::DtW-1:0]    time_step,
  // Result words
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [smtp_pkg::PosW-1:0]   speed_command,
  output logic [smtp_pkg::PosW-1:0]   position,
  output logic                        reached
);

  smtp_pkg::cfg_t  cfg;
  smtp_pkg::item_t item;
  logic            item_valid;
  logic            item_take;

  // Limit registers; the user must write them only while the controller is idle (not enforced).
  smtp_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Capture the command word and precompute max_accel*dt, which needs no state.
  smtp_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .goal_position (goal_position),
    .time_step     (time_step),
    .max_accel     (cfg.max_accel),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take)
  );

  // Apply the word to the move state; the state registers drive the result word
  // and hold while the consumer stalls, which in turn stalls the input stage.
  smtp_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .speed_command (speed_command),
    .position      (position),
    .reached       (reached)
  );

endmodule

### src/smtp_apb_regs.sv
// APB register file holding the speed and acceleration limits.
`timescale 1ns / 1ps

module smtp_apb_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smtp_pkg::AddrW-1:0]    paddr,
  input  logic [smtp_pkg::ApbW-1:0]     pwdata,
  output logic [smtp_pkg::ApbW-1:0]     prdata,
  output logic                          pready,
  output smtp_pkg::cfg_t                cfg
);

  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_speed <= smtp_pkg::MaxSpeedReset;
      cfg.max_accel <= smtp_pkg::MaxAccelReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        smtp_pkg::REG_MAX_SPEED: cfg.max_speed <= pwdata[smtp_pkg::CfgW-1:0];
        smtp_pkg::REG_MAX_ACCEL: cfg.max_accel <= pwdata[smtp_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      smtp_pkg::REG_MAX_SPEED: prdata = {1'b0, cfg.max_speed};
      smtp_pkg::REG_MAX_ACCEL: prdata = {1'b0, cfg.max_accel};
      default:                 prdata = '0;
    endcase
  end

endmodule

### src/smtp_in_stage.sv
// Input register stage; precomputes the acceleration step for the word.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module smtp_in_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  op,
  input  logic [smtp_pkg::PosW-1:0]   goal_position,
  input  logic [smtp_pkg::DtW-1:0]    time_step,
  input  logic [smtp_pkg::CfgW-1:0]   max_accel,
  output logic                        item_valid,
  output smtp_pkg::item_t             item,
  input  logic                        item_take
);

  localparam int unsigned ProdW = smtp_pkg::CfgW + smtp_pkg::DtW;

  logic             accept;
  logic [ProdW-1:0] accel_prod;

  assign in_stall   = item_valid && !item_take;
  assign accept     = in_valid && !in_stall;
  // max_accel*dt, floor to Q16.16.
  assign accel_prod = ProdW'(max_accel) * ProdW'(time_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.op   <= smtp_pkg::op_t'(op);
      item.goal <= goal_position;
      item.dt   <= time_step;
      item.step <= accel_prod[ProdW-1:smtp_pkg::DtW];
    end
  end

  `SMTP_ASSERT_IMPL(a_take_needs_word, clk, rst, item_take, item_valid)
  `SMTP_ASSERT_NEXT(a_stall_keeps_word, clk, rst, in_stall, item_valid)
  `SMTP_ASSERT_NEXT(a_accept_fills, clk, rst, accept, item_valid)

endmodule

### src/smtp_core.sv
// Move state update: integrate, stop check and slew, one word per cycle unless the output stalls.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module smtp_core (
  input  logic                        clk,
  input  logic                        rst,
  input  smtp_pkg::cfg_t              cfg,
  input  logic                        item_valid,
  input  smtp_pkg::item_t             item,
  output logic                        item_take,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [smtp_pkg::PosW-1:0]   speed_command,
  output logic [smtp_pkg::PosW-1:0]   position,
  output logic                        reached
);

  localparam int unsigned PW = smtp_pkg::PosW;

  // State doubles as the result register.
  logic [PW-1:0] speed;
  logic [PW-1:0] pos;
  logic [PW-1:0] goal;
  logic          done;

  logic [PW-1:0] speed_next;
  logic [PW-1:0] pos_next;
  logic [PW-1:0] goal_next;
  logic          done_next;

  logic signed [2*PW-16:0] prod;
  logic signed [2*PW-16:0] prod_rnd;
  logic [PW:0]             rnd;
  logic [PW+1:0]           pos_sum;
  logic [PW-1:0]           pos_sat;
  logic [PW:0]             delta;
  logic                    spd_pos, spd_neg, d_pos, d_neg, stop;
  logic [PW:0]             target;
  logic [PW+1:0]           diff, mag, mv, step_ext, spd_ext, spd_slew;
  logic                    up;

  assign item_take = item_valid && (!out_valid || !out_stall);

  always_comb begin
    // speed*dt in Q16.32, round half up to Q16.16.
    prod     = $signed({{(PW-15){speed[PW-1]}}, speed}) *
               $signed({{(PW-15){1'b0}}, item.dt});
    prod_rnd = prod + (2*PW-15)'(32768);
    rnd      = prod_rnd[2*PW-16:16];
    pos_sum  = {{2{pos[PW-1]}}, pos} + {rnd[PW], rnd};
    if (pos_sum[PW+1:PW-1] == 3'b000 || pos_sum[PW+1:PW-1] == 3'b111) begin
      pos_sat = pos_sum[PW-1:0];
    end else if (pos_sum[PW+1]) begin
      pos_sat = {1'b1, {(PW-1){1'b0}}};
    end else begin
      pos_sat = {1'b0, {(PW-1){1'b1}}};
    end

    delta   = {goal[PW-1], goal} - {pos_sat[PW-1], pos_sat};
    spd_neg = speed[PW-1];
    spd_pos = !speed[PW-1] && (speed != '0);
    d_neg   = delta[PW];
    d_pos   = !delta[PW] && (delta != '0);
    // Overshoot or arrival: speed points away from or onto the goal.
    stop    = (spd_pos && !d_pos) || (spd_neg && !d_neg);

    target   = d_pos ? {2'b00, cfg.max_speed} : -{2'b00, cfg.max_speed};
    spd_ext  = {{2{speed[PW-1]}}, speed};
    diff     = {target[PW], target} - spd_ext;
    up       = !diff[PW+1] && (diff != '0);
    mag      = up ? diff : -diff;
    step_ext = {3'b000, item.step};
    mv       = (mag < step_ext) ? mag : step_ext;
    spd_slew = up ? (spd_ext + mv) : (spd_ext - mv);
  end

  always_comb begin
    speed_next = speed;
    pos_next   = pos;
    goal_next  = goal;
    done_next  = done;
    unique case (item.op)
      smtp_pkg::OP_TICK: begin
        if (!done) begin
          pos_next = pos_sat;
          if (stop) begin
            speed_next = '0;
            done_next  = 1'b1;
          end else begin
            speed_next = spd_slew[PW-1:0];
          end
        end
      end
      smtp_pkg::OP_GOAL: begin
        speed_next = '0;
        goal_next  = item.goal;
        done_next  = 1'b0;
      end
      smtp_pkg::OP_CANCEL: begin
        speed_next = '0;
        done_next  = 1'b1;
      end
      smtp_pkg::OP_ZERO: begin
        pos_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed     <= '0;
      pos       <= '0;
      goal      <= '0;
      done      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (item_take) begin
        speed <= speed_next;
        pos   <= pos_next;
        goal  <= goal_next;
        done  <= done_next;
      end
      if (item_take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign speed_command = speed;
  assign position      = pos;
  assign reached       = done;

  `SMTP_ASSERT_IMPL(a_idle_no_speed, clk, rst, done, speed == '0)
  `SMTP_ASSERT_NEXT(a_cancel_stops, clk, rst, item_take && item.op == smtp_pkg::OP_CANCEL, done)
  `SMTP_ASSERT_NEXT(a_goal_starts, clk, rst, item_take && item.op == smtp_pkg::OP_GOAL, !done)
  `SMTP_ASSERT_NEXT(a_held_result, clk, rst, out_valid && out_stall, $stable(pos) && $stable(speed))

endmodule
